FILE: rtl/ctsk_pkg.sv
package ctsk_pkg;

    // Key event codes.
    localparam logic [1:0] CMD_SELECT = 2'd0;
    localparam logic [1:0] CMD_UP     = 2'd1;
    localparam logic [1:0] CMD_DOWN   = 2'd2;

    // Setting modes.
    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_TIME   = 2'd1;
    localparam logic [1:0] MODE_ALARM  = 2'd2;

    // Number of selects made since entering setting mode.
    localparam logic [3:0] STEP_IDLE      = 4'd0;
    localparam logic [3:0] STEP_YEAR      = 4'd1;
    localparam logic [3:0] STEP_MONTH     = 4'd2;
    localparam logic [3:0] STEP_DAY       = 4'd3;
    localparam logic [3:0] STEP_WEEK      = 4'd4;
    localparam logic [3:0] STEP_HOUR      = 4'd5;
    localparam logic [3:0] STEP_MIN       = 4'd6;
    localparam logic [3:0] STEP_SEC       = 4'd7;
    localparam logic [3:0] STEP_ALARM_HR  = 4'd8;
    localparam logic [3:0] STEP_ALARM_MIN = 4'd9;

    localparam logic [6:0] YEAR_MAX  = 7'd99;
    localparam logic [6:0] MONTH_MAX = 7'd12;
    localparam logic [6:0] WEEK_MAX  = 7'd7;
    localparam logic [6:0] HOUR_MAX  = 7'd23;
    localparam logic [6:0] MIN_MAX   = 7'd59;

    localparam logic [4:0] DAYS_LONG  = 5'd31;
    localparam logic [4:0] DAYS_SHORT = 5'd30;
    localparam logic [4:0] DAYS_FEB   = 5'd28;
    localparam logic [4:0] DAYS_LEAP  = 5'd29;

    typedef struct packed {
        logic [1:0] command;
        logic [6:0] read_value;
        logic [6:0] cur_year;
        logic [3:0] cur_month;
    } t_in_item;

    typedef struct packed {
        logic       write_valid;
        logic [3:0] field;
        logic [6:0] value;
        logic [6:0] led_pattern;
        logic       setting_active;
        logic       alarm_mode;
        logic       show_alarm;
    } t_out_item;

    typedef struct packed {
        logic [1:0] set_mode;
        logic [3:0] field_step;
        logic [6:0] work_value;
        logic [4:0] days_in_month;
        logic [4:0] alarm_hour;
        logic [5:0] alarm_minute;
    } t_state;

endpackage

FILE: rtl/clock_time_set_keys_top.sv
// Pipeline: a request is held in the input register and its result then in
// the result register, from which it can be taken; a stalled result holds
// the request behind it.
// Throughput: one request per cycle while results are taken; the key state
// update is a single combinational pass between the two registers.
// Reset (i_rst_n low at a clock edge) returns to normal display, clears the
// alarm time and sets the month length to 31; both channels come up empty.
module clock_time_set_keys_top
    import ctsk_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    t_state    r_state;
    t_state    n_state;
    t_out_item n_out;
    logic      advance;

    // The held request moves to the result register when that slot is free
    // or is being emptied in the same cycle.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    ctsk_step u_step (
        .i_state  (r_state),
        .i_item   (r_in),
        .o_state  (n_state),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '{set_mode:      MODE_NORMAL,
                             field_step:    STEP_IDLE,
                             work_value:    7'd0,
                             days_in_month: DAYS_LONG,
                             alarm_hour:    5'd0,
                             alarm_minute:  6'd0};
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_in <= i_in_item;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

FILE: rtl/ctsk_step.sv
module ctsk_step
    import ctsk_pkg::*;
(
    input  t_state    i_state,
    input  t_in_item  i_item,
    output t_state    o_state,
    output t_out_item o_result
);

    logic              adjust;
    logic              in_range;
    logic [3:0]        next_step;
    logic [6:0]        lo;
    logic [6:0]        hi;
    logic signed [8:0] stepped;
    logic [6:0]        wrapped;
    logic              active;
    t_state            nxt;

    // Bounds of the field currently being set.
    always_comb begin
        in_range = 1'b1;
        lo       = 7'd0;
        hi       = MIN_MAX;
        case (i_state.field_step)
            STEP_YEAR: begin
                hi = YEAR_MAX;
            end
            STEP_MONTH: begin
                lo = 7'd1;
                hi = MONTH_MAX;
            end
            STEP_DAY: begin
                lo = 7'd1;
                hi = {2'b00, i_state.days_in_month};
            end
            STEP_WEEK: begin
                lo = 7'd1;
                hi = WEEK_MAX;
            end
            STEP_HOUR, STEP_ALARM_HR: begin
                hi = HOUR_MAX;
            end
            STEP_MIN, STEP_SEC, STEP_ALARM_MIN: begin
                hi = MIN_MAX;
            end
            default: begin
                in_range = 1'b0;
            end
        endcase
    end

    always_comb begin
        stepped = $signed({2'b00, i_state.work_value})
                + ((i_item.command == CMD_UP) ? 9'sd1 : -9'sd1);
        if (stepped > $signed({2'b00, hi})) begin
            wrapped = lo;
        end else if (stepped < $signed({2'b00, lo})) begin
            wrapped = hi;
        end else begin
            wrapped = stepped[6:0];
        end
    end

    always_comb begin
        nxt       = i_state;
        adjust    = 1'b0;
        next_step = i_state.field_step + 4'd1;
        o_result  = '0;
        case (i_item.command)
            CMD_SELECT: begin
                if (i_state.set_mode == MODE_NORMAL) begin
                    nxt.set_mode = MODE_TIME;
                end
                nxt.field_step = next_step;
                nxt.work_value = 7'd0;
                if (next_step >= STEP_YEAR && next_step <= STEP_SEC) begin
                    nxt.work_value = i_item.read_value;
                    if (next_step == STEP_DAY) begin
                        case (i_item.cur_month)
                            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: begin
                                nxt.days_in_month = DAYS_LONG;
                            end
                            4'd4, 4'd6, 4'd9, 4'd11: begin
                                nxt.days_in_month = DAYS_SHORT;
                            end
                            4'd2: begin
                                nxt.days_in_month = (i_item.cur_year[1:0] != 2'd0) ?
                                                    DAYS_FEB : DAYS_LEAP;
                            end
                            default: begin
                                nxt.days_in_month = i_state.days_in_month;
                            end
                        endcase
                    end
                end else if (next_step == STEP_ALARM_HR) begin
                    nxt.set_mode   = MODE_ALARM;
                    nxt.work_value = {2'b00, i_state.alarm_hour};
                end else if (next_step == STEP_ALARM_MIN) begin
                    nxt.work_value = {1'b0, i_state.alarm_minute};
                end else begin
                    nxt.field_step = STEP_IDLE;
                    nxt.set_mode   = MODE_NORMAL;
                end
            end
            CMD_UP: begin
                if (i_state.set_mode == MODE_NORMAL) begin
                    o_result.show_alarm = 1'b1;
                end else begin
                    adjust = in_range;
                end
            end
            CMD_DOWN: begin
                adjust = (i_state.set_mode != MODE_NORMAL) && in_range;
            end
            default: begin
                adjust = 1'b0;
            end
        endcase

        if (adjust) begin
            nxt.work_value = wrapped;
            if (i_state.field_step == STEP_ALARM_HR) begin
                nxt.alarm_hour = wrapped[4:0];
            end
            if (i_state.field_step == STEP_ALARM_MIN) begin
                nxt.alarm_minute = wrapped[5:0];
            end
        end

        active = (nxt.set_mode != MODE_NORMAL) &&
                 (nxt.field_step >= STEP_YEAR) && (nxt.field_step <= STEP_ALARM_MIN);
        o_result.write_valid    = adjust;
        o_result.setting_active = (nxt.set_mode != MODE_NORMAL);
        o_result.alarm_mode     = (nxt.set_mode == MODE_ALARM);
        if (active) begin
            o_result.field = nxt.field_step - 4'd1;
            o_result.value = nxt.work_value;
            case (nxt.field_step)
                STEP_ALARM_HR:  o_result.led_pattern = 7'h10;
                STEP_ALARM_MIN: o_result.led_pattern = 7'h20;
                default:        o_result.led_pattern = 7'd1 << (nxt.field_step[2:0] - 3'd1);
            endcase
        end
        o_state = nxt;
    end

endmodule
